// File: hdl/teq_pkg.sv
// ----------------------------------------------------------------------------
// Timed event queue package
// Field widths, operation and status codes and the types shared by the
// queue cells and the top level.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int TIME_W  = 48;
    localparam int TAG_W   = 16;
    localparam int SEQ_W   = 32;
    localparam int DELAY_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
        logic [SEQ_W-1:0]  seq;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t entry;
    } cmd_t;

endpackage

// File: hdl/teq_cell.sv
// ----------------------------------------------------------------------------
// Timed event queue cell
// Holds one queue entry. On an insert it keeps its entry, takes the new
// event or takes its left neighbour's entry; on a pop it takes its right
// neighbour's entry.
// ----------------------------------------------------------------------------
module teq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic              clk,
    input  teq_pkg::cmd_t     cmd,
    input  logic [CNT_W-1:0]  occupancy,
    input  teq_pkg::entry_t   left_entry,
    input  logic              left_keep,
    input  teq_pkg::entry_t   right_entry,
    output logic              keep,
    output teq_pkg::entry_t   entry
);
    import teq_pkg::*;

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;

    // Strictly earlier entries stay put, so a new event goes ahead of equal times.
    assign keep = (SLOT < occupancy) && (entry_reg.due < cmd.entry.due);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && !keep)
        begin
            entry_next = left_keep ? cmd.entry : left_entry;
        end
        else if (cmd.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hdl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// Timed event queue
// Sorted discrete-event queue built as a chain of cells, earliest event in
// the first cell.
// ----------------------------------------------------------------------------
// The result strobe (done) is registered from busy after start is taken.
// A new transaction is not taken while busy is high; busy is high for the cycle
// in which the registered due time is compared in every cell of the chain.
// Reset clears the pending and peak counts, the current time and the sequence
// counter; entry storage is not cleared. The receiver cannot stall results.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [teq_pkg::OP_W-1:0]                 operation,
    input  logic [teq_pkg::DELAY_W-1:0]              delay,
    input  logic [teq_pkg::TAG_W-1:0]                event_tag,
    output logic                                     done,
    output logic [teq_pkg::STAT_W-1:0]               status,
    output logic [teq_pkg::TIME_W-1:0]               due_time,
    output logic [teq_pkg::TAG_W-1:0]                out_tag,
    output logic [teq_pkg::SEQ_W-1:0]                sequence_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         pending_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         peak_count
);
    import teq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic                busy_reg;
    logic                busy_next;
    logic [OP_W-1:0]     op_reg;
    logic [TIME_W-1:0]   due_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;
    logic [SEQ_W-1:0]    seq_reg;
    logic [SEQ_W-1:0]    seq_next;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    logic [CNT_W-1:0]    peak_reg;
    logic [CNT_W-1:0]    peak_next;
    logic                done_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    entry_t              result_reg;
    entry_t              result_next;

    logic                accept;
    logic [TIME_W:0]     due_sum;
    logic [TIME_W-1:0]   due_sat;
    logic                is_full;
    logic                is_empty;
    cmd_t                cmd;
    entry_t              cell_entry [QUEUE_DEPTH];
    logic                cell_keep  [QUEUE_DEPTH];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Due time is registered before the cells compare against it.
    assign due_sum = {1'b0, now_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
    assign due_sat = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            due_reg <= due_sat;
            tag_reg <= event_tag;
        end
    end

    assign is_full  = (occ_reg == FULL_CNT);
    assign is_empty = (occ_reg == '0);

    always_comb
    begin
        cmd.insert    = busy_reg && (op_reg == OP_ADD) && !is_full;
        cmd.pop       = busy_reg && (op_reg == OP_POP) && !is_empty;
        cmd.entry.due = due_reg;
        cmd.entry.tag = tag_reg;
        cmd.entry.seq = seq_reg + SEQ_W'(1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_k;
            entry_t right_e;

            if (gi == 0)
            begin : g_first
                assign left_e = cmd.entry;
                assign left_k = 1'b1;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            teq_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupancy   (occ_reg),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .keep        (cell_keep[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next   = accept;
        now_next    = now_reg;
        seq_next    = seq_reg;
        occ_next    = occ_reg;
        peak_next   = peak_reg;
        status_next = STAT_OK;
        result_next = '0;
        if (busy_reg)
        begin
            unique case (op_reg)
                OP_ADD:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        seq_next    = cmd.entry.seq;
                        occ_next    = occ_reg + CNT_W'(1);
                        result_next = cmd.entry;
                        if (occ_next > peak_reg)
                        begin
                            peak_next = occ_next;
                        end
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        occ_next    = occ_reg - CNT_W'(1);
                        now_next    = cell_entry[0].due;
                        result_next = cell_entry[0];
                    end
                end
                OP_FLUSH:
                begin
                    occ_next = '0;
                    seq_next = '0;
                    now_next = '0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            now_reg  <= '0;
            seq_reg  <= '0;
            occ_reg  <= '0;
            peak_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= busy_reg;
            now_reg  <= now_next;
            seq_reg  <= seq_next;
            occ_reg  <= occ_next;
            peak_reg <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign due_time      = result_reg.due;
    assign out_tag       = result_reg.tag;
    assign sequence_id   = result_reg.seq;
    assign pending_count = occ_reg;
    assign peak_count    = peak_reg;

    // A transaction in the compare cycle always yields a result strobe next.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> done_reg)
        else $error("result strobe missing after compare cycle");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !done_reg)
        else $error("result strobe without a transaction");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("pending count above queue depth");

    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= occ_reg)
        else $error("peak count below pending count");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Timed event queue testbench
// Drives add, pop, flush and unused-code transactions into the queue and
// checks every result strobe against a behavioural schedule kept in the
// bench. A directed opening and a short run of very large delays are
// followed by random bursts under several sender idling rates.
// ----------------------------------------------------------------------------
module tb_top;

    import teq_pkg::*;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [OP_W-1:0]   OP_NOP   = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DELAY_W-1:0] dly;
        logic [TAG_W-1:0]   tg;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TIME_W-1:0] due;
        logic [TAG_W-1:0]  tag;
        logic [SEQ_W-1:0]  seq;
        logic [CNT_W-1:0]  pending;
        logic [CNT_W-1:0]  peak;
    } event_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OP_W-1:0]     operation = '0;
    logic [DELAY_W-1:0]  delay = '0;
    logic [TAG_W-1:0]    event_tag = '0;
    logic                busy;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [TIME_W-1:0]   due_time;
    logic [TAG_W-1:0]    out_tag;
    logic [SEQ_W-1:0]    sequence_id;
    logic [CNT_W-1:0]    pending_count;
    logic [CNT_W-1:0]    peak_count;

    cmd_item_t       cmd_q[$];
    event_result_t   due_results[$];

    // Schedule as the queue should hold it, earliest event first.
    entry_t          sched_events[$];
    logic [TIME_W-1:0] sched_now = '0;
    logic [SEQ_W-1:0]  sched_seq = '0;
    int              sched_peak = 0;

    int idle_pct = 0;
    int mismatches = 0;
    int n_adds = 0, n_full = 0, n_pops = 0, n_empty = 0, n_flush = 0, n_nop = 0;
    int n_saturated = 0, n_results = 0;

    timed_event_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .delay         (delay),
        .event_tag     (event_tag),
        .done          (done),
        .status        (status),
        .due_time      (due_time),
        .out_tag       (out_tag),
        .sequence_id   (sequence_id),
        .pending_count (pending_count),
        .peak_count    (peak_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one transaction to the schedule and returns the result it causes.
    function automatic event_result_t schedule_transaction(cmd_item_t c);
        event_result_t r;
        entry_t        ev;
        logic [TIME_W:0] sum;
        int            pos;
        r = '0;
        case (c.op)
            OP_ADD:
            begin
                if (sched_events.size() >= DEPTH)
                begin
                    r.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    sum = {1'b0, sched_now} + {{(TIME_W - DELAY_W + 1){1'b0}}, c.dly};
                    if (sum > {1'b0, TIME_MAX})
                    begin
                        ev.due = TIME_MAX;
                        n_saturated++;
                    end
                    else
                        ev.due = sum[TIME_W-1:0];
                    sched_seq = sched_seq + SEQ_W'(1);
                    ev.tag = c.tg;
                    ev.seq = sched_seq;
                    // A new event goes ahead of waiting ones with an equal due time.
                    pos = 0;
                    while (pos < sched_events.size() && sched_events[pos].due < ev.due)
                        pos++;
                    sched_events.insert(pos, ev);
                    if (sched_events.size() > sched_peak)
                        sched_peak = sched_events.size();
                    r.status = STAT_OK;
                    r.due = ev.due;
                    r.tag = ev.tag;
                    r.seq = ev.seq;
                end
                n_adds++;
            end
            OP_POP:
            begin
                if (sched_events.size() == 0)
                begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end
                else
                begin
                    ev = sched_events.pop_front();
                    sched_now = ev.due;
                    r.status = STAT_OK;
                    r.due = ev.due;
                    r.tag = ev.tag;
                    r.seq = ev.seq;
                end
                n_pops++;
            end
            OP_FLUSH:
            begin
                sched_events.delete();
                sched_seq = '0;
                sched_now = '0;
                n_flush++;
            end
            default:
                n_nop++;
        endcase
        r.pending = CNT_W'(sched_events.size());
        r.peak = CNT_W'(sched_peak);
        return r;
    endfunction

    // Driver: a transaction is taken at an edge where start is high and busy low.
    always @(posedge clk)
    begin : drive_proc
        cmd_item_t c;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                due_results.push_back(schedule_transaction({operation, delay, event_tag}));
            if (!start || !busy)
            begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    c = cmd_q.pop_front();
                    start     <= 1'b1;
                    operation <= c.op;
                    delay     <= c.dly;
                    event_tag <= c.tg;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is matched with the oldest outstanding result.
    always @(posedge clk)
    begin : watch_proc
        event_result_t e;
        if (rst_n && done)
        begin
            n_results++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result strobe with no transaction outstanding", $time);
            end
            else
            begin
                e = due_results.pop_front();
                if (status !== e.status || due_time !== e.due || out_tag !== e.tag ||
                    sequence_id !== e.seq || pending_count !== e.pending ||
                    peak_count !== e.peak)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("%0t: mismatch (expected/actual): status %0d/%0d due %h/%h ",
                               $time, e.status, status, e.due, due_time);
                        $display("tag %h/%h seq %h/%h pending %0d/%0d peak %0d/%0d",
                                 e.tag, out_tag, e.seq, sequence_id, e.pending,
                                 pending_count, e.peak, peak_count);
                    end
                end
            end
        end
    end

    task automatic push_cmd(logic [OP_W-1:0] op, logic [DELAY_W-1:0] dly,
                            logic [TAG_W-1:0] tg);
        cmd_q.push_back({op, dly, tg});
    endtask

    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(4))
            0:       return $urandom_range(7);
            1:       return $urandom_range(65535);
            2:       return $urandom_range(1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    // Waits on the falling edge so that every driver and monitor update has settled.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || start || due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random(int n);
        int made;
        int kind;
        int len;
        int pick;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                // A long run of 60 to 70 adds that can drive the queue to full and beyond.
                len = 60 + $urandom_range(10);
                repeat (len) push_cmd(OP_ADD, pick_delay(), TAG_W'($urandom));
            end
            else if (kind <= 2)
            begin
                len = 1 + $urandom_range(15);
                repeat (len) push_cmd(OP_POP, $urandom, TAG_W'($urandom));
            end
            else
            begin
                len = 1 + $urandom_range(12);
                repeat (len)
                begin
                    pick = $urandom_range(99);
                    if (pick < 55)
                        push_cmd(OP_ADD, pick_delay(), TAG_W'($urandom));
                    else if (pick < 85)
                        push_cmd(OP_POP, $urandom, TAG_W'($urandom));
                    else if (pick < 92)
                        push_cmd(OP_FLUSH, $urandom, TAG_W'($urandom));
                    else
                        push_cmd(OP_NOP, $urandom, TAG_W'($urandom));
                end
            end
            made += len;
        end
    endtask

    initial
    begin : stim_proc
        int phase_idle[4];
        phase_idle = '{0, 75, 0, 7};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: empty queue, extremes, equal due times, flush.
        push_cmd(OP_FLUSH, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_NOP, '1, '1);
        push_cmd(OP_ADD, '0, '0);
        push_cmd(OP_ADD, '1, '1);
        push_cmd(OP_ADD, '0, 16'h1234);
        push_cmd(OP_ADD, 32'd5, 16'h0005);
        push_cmd(OP_ADD, 32'd5, 16'h0006);
        push_cmd(OP_POP, '1, '1);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_ADD, 32'd3, 16'hA5A5);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_ADD, 32'd100, 16'h5A5A);
        push_cmd(OP_ADD, 32'h0001_0000, 16'h0F0F);
        push_cmd(OP_FLUSH, '1, '1);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_ADD, 32'h8000_0000, 16'h8001);
        push_cmd(OP_NOP, $urandom, TAG_W'($urandom));
        push_cmd(OP_POP, '0, '0);
        idle_pct = 0;
        wait_drained();

        // Step the current time up by the largest delay a few times over.
        for (int i = 0; i < 8; i++)
        begin
            push_cmd(OP_ADD, '1, TAG_W'($urandom));
            push_cmd(OP_POP, '0, '0);
        end
        push_cmd(OP_ADD, '1, 16'hFFFF);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_ADD, '0, 16'h0001);
        push_cmd(OP_ADD, '1, 16'h0002);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_POP, '0, '0);
        push_cmd(OP_FLUSH, '0, '0);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            queue_random(115);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Covered %0d transactions: %0d adds (%0d on a full queue, %0d saturated),",
                 n_adds + n_pops + n_flush + n_nop, n_adds, n_full, n_saturated);
        $display("%0d pops (%0d on an empty queue), %0d flushes, %0d unused codes, %0d results.",
                 n_pops, n_empty, n_flush, n_nop, n_results);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/timed_event_queue.sv
verif/tb_top.sv
